// File: rtl/rwat_pkg.sv
// ----------------------------------------------------------------------------
// rwat_pkg - shared types and constants for the replay window ack tracker
// Word layouts, status codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package rwat_pkg;

   localparam int SEQ_WIDTH       = 16;
   localparam int MAGIC_WIDTH     = 32;
   localparam int LENGTH_WIDTH    = 16;
   localparam int STATUS_WIDTH    = 3;
   localparam int ACK_HIST_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int DEF_WINDOW_BITS  = 64;
   localparam int DEF_HISTORY_BITS = 16;

   localparam logic [SEQ_WIDTH-1:0]    HALF_RANGE        = 16'h8000;
   localparam logic [LENGTH_WIDTH-1:0] MIN_LENGTH_RESET  = 16'd12;
   localparam logic [MAGIC_WIDTH-1:0]  MAGIC_RESET       = 32'h0000_0000;

   // request kinds
   localparam logic REQ_CHECK = 1'b0;
   localparam logic REQ_STAMP = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAGIC      = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_LENGTH = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_BAD_MAGIC = 3'd2,
      STATUS_DUPLICATE = 3'd3,
      STATUS_TOO_OLD   = 3'd4
   } status_type;

   typedef struct packed {
      logic                    req_type;
      logic [SEQ_WIDTH-1:0]    rx_sequence;
      logic [MAGIC_WIDTH-1:0]  rx_magic;
      logic [LENGTH_WIDTH-1:0] rx_length;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]   status;
      logic [SEQ_WIDTH-1:0]      tx_sequence;
      logic [SEQ_WIDTH-1:0]      ack_sequence;
      logic [ACK_HIST_WIDTH-1:0] ack_history;
   } rsp_word_type;

   typedef struct packed {
      logic [MAGIC_WIDTH-1:0]  magic_value;
      logic [LENGTH_WIDTH-1:0] min_length;
   } cfg_type;

endpackage

// File: rtl/rwat_csr.sv
// ----------------------------------------------------------------------------
// rwat_csr - configuration registers
// Holds the expected magic word and the minimum datagram length.
// ----------------------------------------------------------------------------
module rwat_csr import rwat_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   logic [MAGIC_WIDTH-1:0]  magic_ff;
   logic [LENGTH_WIDTH-1:0] min_length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff      <= MAGIC_RESET;
         min_length_ff <= MIN_LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAGIC:      magic_ff      <= csr_data[MAGIC_WIDTH-1:0];
            CSR_MIN_LENGTH: min_length_ff <= csr_data[LENGTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.magic_value = magic_ff;
   assign cfg.min_length  = min_length_ff;

endmodule

// File: rtl/rwat_window.sv
// ----------------------------------------------------------------------------
// rwat_window - header check, replay window and ack history
// Computes the result of one word from the current state and commits the
// new state when the word moves to the result register.
// ----------------------------------------------------------------------------
module rwat_window import rwat_pkg::*; #(
   parameter int WINDOW_BITS  = DEF_WINDOW_BITS,
   parameter int HISTORY_BITS = DEF_HISTORY_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_word_type item,
   input  cfg_type      cfg,
   output rsp_word_type result
);

   logic [SEQ_WIDTH-1:0]    newest_ff, newest_in;
   logic [WINDOW_BITS-1:0]  mask_ff, mask_in;
   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic                    seen_ff, seen_in;
   logic [SEQ_WIDTH-1:0]    next_tx_ff, next_tx_in;

   logic [SEQ_WIDTH-1:0]    fwd;
   logic [SEQ_WIDTH-1:0]    bwd;
   logic                    is_newer;
   status_type              status;
   logic [SEQ_WIDTH-1:0]    tx_sequence;

   assign fwd = item.rx_sequence - newest_ff;
   assign bwd = newest_ff - item.rx_sequence;
   // half-range compare; an exact half distance goes by numeric order
   assign is_newer = (fwd != '0) &&
                     (!fwd[SEQ_WIDTH-1] ||
                      (fwd == HALF_RANGE && item.rx_sequence > newest_ff));

   always_comb begin
      newest_in   = newest_ff;
      mask_in     = mask_ff;
      hist_in     = hist_ff;
      seen_in     = seen_ff;
      next_tx_in  = next_tx_ff;
      status      = STATUS_OK;
      tx_sequence = '0;
      if (item.req_type == REQ_STAMP) begin
         tx_sequence = next_tx_ff;
         next_tx_in  = next_tx_ff + SEQ_WIDTH'(1);
      end else if (item.rx_length == '0 || item.rx_length < cfg.min_length) begin
         status = STATUS_SHORT;
      end else if (item.rx_magic != cfg.magic_value) begin
         status = STATUS_BAD_MAGIC;
      end else if (!seen_ff) begin
         // first packet: window holds only itself, history empty
         seen_in   = 1'b1;
         newest_in = item.rx_sequence;
         mask_in   = WINDOW_BITS'(1);
         hist_in   = '0;
      end else if (is_newer) begin
         newest_in = item.rx_sequence;
         if (fwd >= SEQ_WIDTH'(WINDOW_BITS)) begin
            mask_in = WINDOW_BITS'(1);
         end else begin
            mask_in = (mask_ff << fwd) | WINDOW_BITS'(1);
         end
         if (fwd > SEQ_WIDTH'(HISTORY_BITS)) begin
            hist_in = '0;
         end else begin
            // old newest lands at bit fwd-1
            hist_in = (hist_ff << fwd) | (HISTORY_BITS'(1) << (fwd - SEQ_WIDTH'(1)));
         end
      end else if (bwd >= SEQ_WIDTH'(WINDOW_BITS)) begin
         status = STATUS_TOO_OLD;
      end else if (|(mask_ff & (WINDOW_BITS'(1) << bwd))) begin
         status = STATUS_DUPLICATE;
      end else begin
         mask_in = mask_ff | (WINDOW_BITS'(1) << bwd);
         if (bwd != '0 && bwd <= SEQ_WIDTH'(HISTORY_BITS)) begin
            hist_in = hist_ff | (HISTORY_BITS'(1) << (bwd - SEQ_WIDTH'(1)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff  <= '0;
         mask_ff    <= '0;
         hist_ff    <= '0;
         seen_ff    <= 1'b0;
         next_tx_ff <= '0;
      end else if (step) begin
         newest_ff  <= newest_in;
         mask_ff    <= mask_in;
         hist_ff    <= hist_in;
         seen_ff    <= seen_in;
         next_tx_ff <= next_tx_in;
      end
   end

   assign result.status       = status;
   assign result.tx_sequence  = tx_sequence;
   assign result.ack_sequence = newest_in;
   assign result.ack_history  = ACK_HIST_WIDTH'(hist_in);

endmodule

// File: rtl/replay_window_ack_tracker_unit.sv
// ----------------------------------------------------------------------------
// replay_window_ack_tracker_unit - anti-replay window with ack tracking
// Checks received headers against a sliding replay window and stamps
// outgoing packets with sequence, ack and ack history.
// ----------------------------------------------------------------------------
// Each request word is either a receive check or a send stamp and produces
// exactly one response word. A word waits in the input register, where the
// length, magic and window checks run as one short combinational pass; the
// result and the new window state are captured together when the word moves
// to the response register. The block takes one word per cycle while the
// response register is empty or being taken: state is committed in the same
// cycle that the word moves to the response register, so the next word sees
// it at once. A full response register that is not taken stalls the input
// register, and req_ready follows. Configuration writes are taken in any
// cycle (csr_ready is tied high) but are meant to happen only while idle.
// ----------------------------------------------------------------------------
module replay_window_ack_tracker_unit import rwat_pkg::*; #(
   parameter int WINDOW_BITS  = DEF_WINDOW_BITS,
   parameter int HISTORY_BITS = DEF_HISTORY_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_word_type               req_data,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_word_type               rsp_data,
   // configuration writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type      cfg;
   logic         req_valid_ff;
   req_word_type req_data_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;
   rsp_word_type result;
   logic         out_free;
   logic         stage_fire;

   // response slot can take a word this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // word in the input register is checked and committed
   assign stage_fire = req_valid_ff && out_free;
   assign req_ready  = !req_valid_ff || out_free;

   rwat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rwat_window #(
      .WINDOW_BITS  (WINDOW_BITS),
      .HISTORY_BITS (HISTORY_BITS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .step   (stage_fire),
      .item   (req_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a stamp always succeeds and lands in the response register
   a_stamp_ok : assert property (@(posedge clock) disable iff (reset)
      stage_fire && req_data_ff.req_type == REQ_STAMP
      |=> rsp_valid_ff && rsp_data_ff.status == STATUS_OK)
      else $error("stamp response missing or not ok");

   // receive checks never carry a transmit sequence
   a_check_no_tx : assert property (@(posedge clock) disable iff (reset)
      stage_fire && req_data_ff.req_type == REQ_CHECK
      |=> rsp_data_ff.tx_sequence == '0)
      else $error("receive response carries tx sequence");

   // a held word is never dropped from the input register
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !stage_fire |=> req_valid_ff)
      else $error("stalled request word lost");

endmodule

// File: tb/ack_tracker_checker.sv
// ----------------------------------------------------------------------------
// ack_tracker_checker - response checker for the replay window ack tracker
// Watches the request, response and register channels, tracks the replay
// window and ack history on its own, and compares every response word.
// ----------------------------------------------------------------------------
module ack_tracker_checker import rwat_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  req_word_type               req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rsp_word_type               rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                         mismatch_count,
   output int                         words_pending
);

   logic [MAGIC_WIDTH-1:0]      magic_cfg;
   logic [LENGTH_WIDTH-1:0]     min_length_cfg;
   logic [SEQ_WIDTH-1:0]        newest_seq;
   logic [SEQ_WIDTH-1:0]        next_tx_seq;
   logic [DEF_WINDOW_BITS-1:0]  seen_window;
   logic [ACK_HIST_WIDTH-1:0]   ack_bits;
   logic                        any_accepted;
   rsp_word_type                expected_rsp_q[$];
   int                          mismatches = 0;
   int                          pending = 0;

   assign mismatch_count = mismatches;
   assign words_pending  = pending;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatches < 50)
         $display("MISMATCH %s: expected %0h, got %0h (t=%0t)", what, want, got, $realtime);
      mismatches++;
   endtask

   // window check of a receive that passed length and magic; commits state
   function automatic status_type window_check(input logic [SEQ_WIDTH-1:0] seq);
      logic [SEQ_WIDTH-1:0] fwd;
      logic [SEQ_WIDTH-1:0] back;
      logic [31:0]          hist_wide;
      if (!any_accepted) begin
         any_accepted = 1'b1;
         newest_seq   = seq;
         seen_window  = DEF_WINDOW_BITS'(1);
         ack_bits     = '0;
         return STATUS_OK;
      end
      fwd = seq - newest_seq;
      if (fwd != 0 && (fwd < HALF_RANGE || (fwd == HALF_RANGE && seq > newest_seq))) begin
         if (fwd >= DEF_WINDOW_BITS)
            seen_window = '0;
         else
            seen_window = seen_window << fwd;
         seen_window[0] = 1'b1;
         if (fwd > DEF_HISTORY_BITS) begin
            ack_bits = '0;
         end else begin
            hist_wide = ({16'd0, ack_bits} << fwd) | (32'd1 << (fwd - 1));
            ack_bits  = hist_wide[ACK_HIST_WIDTH-1:0];
         end
         newest_seq = seq;
         return STATUS_OK;
      end
      back = newest_seq - seq;
      if (back >= DEF_WINDOW_BITS)
         return STATUS_TOO_OLD;
      if (seen_window[back])
         return STATUS_DUPLICATE;
      seen_window[back] = 1'b1;
      if (back >= 1 && back - 1 < DEF_HISTORY_BITS)
         ack_bits[back-1] = 1'b1;
      return STATUS_OK;
   endfunction

   function automatic rsp_word_type track_word(input req_word_type w);
      rsp_word_type r;
      status_type   st;
      st            = STATUS_OK;
      r.tx_sequence = '0;
      if (w.req_type == REQ_STAMP) begin
         r.tx_sequence = next_tx_seq;
         next_tx_seq   = next_tx_seq + 1'b1;
      end else if (w.rx_length == 0 || w.rx_length < min_length_cfg) begin
         st = STATUS_SHORT;
      end else if (w.rx_magic != magic_cfg) begin
         st = STATUS_BAD_MAGIC;
      end else begin
         st = window_check(w.rx_sequence);
      end
      r.status       = st;
      r.ack_sequence = newest_seq;
      r.ack_history  = ack_bits;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         magic_cfg      = MAGIC_RESET;
         min_length_cfg = MIN_LENGTH_RESET;
         newest_seq     = '0;
         next_tx_seq    = '0;
         seen_window    = '0;
         ack_bits       = '0;
         any_accepted   = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAGIC:      magic_cfg = csr_data;
               CSR_MIN_LENGTH: min_length_cfg = csr_data[LENGTH_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response word with none pending", '0,
                               32'(rsp_data.ack_sequence));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_data.status));
               if (rsp_data.tx_sequence !== want.tx_sequence)
                  report_mismatch("tx_sequence", 32'(want.tx_sequence),
                                  32'(rsp_data.tx_sequence));
               if (rsp_data.ack_sequence !== want.ack_sequence)
                  report_mismatch("ack_sequence", 32'(want.ack_sequence),
                                  32'(rsp_data.ack_sequence));
               if (rsp_data.ack_history !== want.ack_history)
                  report_mismatch("ack_history", 32'(want.ack_history),
                                  32'(rsp_data.ack_history));
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(track_word(req_data));
      end
      pending <= expected_rsp_q.size();
   end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - top level for the replay window ack tracker
// Drives request words and register writes, throttles the response side and
// reports the verdict; all checking lives in ack_tracker_checker.
// ----------------------------------------------------------------------------
module testbench import rwat_pkg::*; ();

   localparam int HOLD_CYCLES  = 60;      // long receiver hold-off
   localparam int SETTLE_CYCLES = 4;      // pipeline is two deep
   localparam int STAMP_BURST  = 50;      // full-rate stamp run

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_MAGIC;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   int                         mismatch_count;
   int                         words_pending;

   // traffic shaping shared by the sender and the response throttle
   bit                         idle_on = 1'b1;
   int                         hold_requests = 0;
   logic [MAGIC_WIDTH-1:0]     magic_now = MAGIC_RESET;
   logic [LENGTH_WIDTH-1:0]    min_len_now = MIN_LENGTH_RESET;
   logic [SEQ_WIDTH-1:0]       seq_cursor = '0;   // rough idea of the newest sequence

   always #6 clock = ~clock;

   replay_window_ack_tracker_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ack_tracker_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // Response throttle: about 11% stall cycles when idling is on. A hold
   // request drops ready for a long stretch so the pipeline fills and
   // req_ready falls while the sender keeps offering.
   initial begin
      int holds_served;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99, 0) < 11);
         end
      end
   end

   // Called at a falling edge, returns at the falling edge after the word
   // is taken. Valid stays high so back-to-back words need no extra step.
   task automatic send_word(input req_word_type w);
      if (idle_on && $urandom_range(99, 0) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_word_type rx_word(input logic [SEQ_WIDTH-1:0] seq,
                                            input logic [MAGIC_WIDTH-1:0] magic,
                                            input logic [LENGTH_WIDTH-1:0] len);
      req_word_type w;
      w.req_type    = REQ_CHECK;
      w.rx_sequence = seq;
      w.rx_magic    = magic;
      w.rx_length   = len;
      return w;
   endfunction

   // rx fields of a stamp are don't-care, so fill them with noise
   function automatic req_word_type stamp_word();
      req_word_type w;
      w.req_type    = REQ_STAMP;
      w.rx_sequence = SEQ_WIDTH'($urandom);
      w.rx_magic    = $urandom;
      w.rx_length   = LENGTH_WIDTH'($urandom);
      return w;
   endfunction

   // drop valid and wait until every response word has been checked
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
   endtask

   // register writes only with the block empty
   task automatic reconfigure(input logic [MAGIC_WIDTH-1:0] magic,
                              input logic [LENGTH_WIDTH-1:0] min_len);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_MAGIC;
      csr_data  <= magic;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= CSR_MIN_LENGTH;
      csr_data  <= {{(CSR_DATA_WIDTH-LENGTH_WIDTH){1'b0}}, min_len};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid   <= 1'b0;
      magic_now   = magic;
      min_len_now = min_len;
   endtask

   // Mostly well-formed receives walking forward from seq_cursor, with
   // replays, old and far jumps, half-range jumps, bad headers and stamps.
   // quiet_until: words sent with idling off; hold_at / drain_at: word
   // index of the receiver hold-off / sender pause, -1 for none.
   task automatic run_traffic(input int count, input int quiet_until,
                              input int hold_at, input int drain_at);
      int                      roll;
      logic [SEQ_WIDTH-1:0]    seq;
      logic [MAGIC_WIDTH-1:0]  magic;
      logic [LENGTH_WIDTH-1:0] len;
      int                      lo;
      for (int i = 0; i < count; i++) begin
         idle_on = (i >= quiet_until);
         if (i == hold_at)
            hold_requests++;
         if (i == drain_at)
            drain();
         if ($urandom_range(99, 0) < 20) begin
            send_word(stamp_word());
         end else begin
            roll = $urandom_range(99, 0);
            if (roll < 55) begin
               seq_cursor = seq_cursor + SEQ_WIDTH'($urandom_range(3, 1));
               seq = seq_cursor;
            end else if (roll < 80) begin
               seq = seq_cursor - SEQ_WIDTH'($urandom_range(70, 0));
            end else if (roll < 90) begin
               seq_cursor = seq_cursor + SEQ_WIDTH'($urandom_range(80, 4));
               seq = seq_cursor;
            end else if (roll < 95) begin
               seq_cursor = seq_cursor + HALF_RANGE;
               seq = seq_cursor;
            end else begin
               seq_cursor = SEQ_WIDTH'($urandom);
               seq = seq_cursor;
            end
            magic = ($urandom_range(99, 0) < 88) ? magic_now : MAGIC_WIDTH'($urandom);
            if ($urandom_range(99, 0) < 85) begin
               lo  = (min_len_now == 0) ? 1 : int'(min_len_now);
               len = LENGTH_WIDTH'($urandom_range(65535, lo));
            end else begin
               len = (min_len_now == 0) ? '0 : LENGTH_WIDTH'($urandom_range(min_len_now - 1, 0));
            end
            send_word(rx_word(seq, magic, len));
         end
      end
      idle_on = 1'b1;
   endtask

   // Stimulus
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: header checks, first packet, window and history edges
      reconfigure(32'h5A5A_C3C3, 16'd12);
      send_word(rx_word(16'h0005, 32'h5A5A_C3C3, 16'd0));      // zero length
      send_word(rx_word(16'h0005, 32'h0000_0000, 16'd11));     // short wins over magic
      send_word(rx_word(16'h0005, 32'hFFFF_FFFF, 16'd12));     // bad magic
      send_word(stamp_word());
      send_word(rx_word(16'hFFFE, 32'h5A5A_C3C3, 16'hFFFF));   // first packet
      send_word(rx_word(16'hFFFE, 32'h5A5A_C3C3, 16'd12));     // repeat of newest
      send_word(rx_word(16'hFFFF, 32'h5A5A_C3C3, 16'd12));     // step of one
      send_word(rx_word(16'h0003, 32'h5A5A_C3C3, 16'd100));    // wraps through zero
      send_word(rx_word(16'h0001, 32'h5A5A_C3C3, 16'd100));    // older, fresh
      send_word(rx_word(16'h0001, 32'h5A5A_C3C3, 16'd100));    // older, replay
      send_word(rx_word(16'h0042, 32'h5A5A_C3C3, 16'd100));    // shift by 63
      send_word(rx_word(16'h0003, 32'h5A5A_C3C3, 16'd100));    // oldest window slot
      send_word(rx_word(16'h0002, 32'h5A5A_C3C3, 16'd100));    // just past the window
      send_word(rx_word(16'h0082, 32'h5A5A_C3C3, 16'd100));    // shift by 64 clears
      send_word(rx_word(16'h0092, 32'h5A5A_C3C3, 16'd100));    // shift by 16
      send_word(rx_word(16'h0091, 32'h5A5A_C3C3, 16'd100));    // history bit zero
      send_word(rx_word(16'h00A3, 32'h5A5A_C3C3, 16'd100));    // shift by 17 clears
      send_word(rx_word(16'h80A3, 32'h5A5A_C3C3, 16'd100));    // half range, larger
      send_word(rx_word(16'h00A3, 32'h5A5A_C3C3, 16'd100));    // half range, smaller
      send_word(rx_word(16'h0000, 32'h5A5A_C3C3, 16'd100));
      send_word(rx_word(16'h8000, 32'h5A5A_C3C3, 16'd100));
      send_word(rx_word(16'h0000, 32'h5A5A_C3C3, 16'd100));
      send_word(stamp_word());
      reconfigure(32'hFFFF_FFFF, 16'd0);
      send_word(rx_word(16'h8001, 32'hFFFF_FFFF, 16'd0));      // zero length, no minimum
      send_word(rx_word(16'h8001, 32'hFFFF_FFFF, 16'd1));
      seq_cursor = 16'h8001;

      // stamp burst at full rate
      idle_on = 1'b0;
      for (int i = 0; i < STAMP_BURST; i++)
         send_word(stamp_word());
      idle_on = 1'b1;

      // random phases, register extremes included
      reconfigure(32'h0000_0000, 16'd0);
      run_traffic(250, 150, -1, -1);
      reconfigure(32'hFFFF_FFFF, 16'hFFFF);
      run_traffic(250, 0, 100, -1);
      reconfigure($urandom, 16'd12);
      run_traffic(250, 0, -1, 140);
      reconfigure($urandom, LENGTH_WIDTH'($urandom_range(1500, 1)));
      run_traffic(250, 0, 60, 200);

      // let everything drain, then a short tail for stray words
      drain();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: several times the slowest legal run
   initial begin
      #(12 * 500000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
